// ===== rtl/ort_pkg.sv =====
// Shared types and constants for the outstanding request tracker.
package ort_pkg;

  localparam int KEY_W   = 64;
  localparam int WORD_W  = 32;
  localparam int PEER_W  = 4;
  localparam int TOUT_W  = 16;
  localparam int OP_W    = 3;
  localparam int KIND_W  = 2;
  localparam int CFG_IDX_W = 1;

  // Upper bound on the number of entries one query reports.
  localparam int MAX_RESULTS = 16;
  localparam int CNT_W = $clog2(MAX_RESULTS);

  localparam logic [OP_W-1:0] OP_CREATE     = 3'd0;
  localparam logic [OP_W-1:0] OP_COMPLETE   = 3'd1;
  localparam logic [OP_W-1:0] OP_EXPIRE     = 3'd2;
  localparam logic [OP_W-1:0] OP_DROP_PEER  = 3'd3;
  localparam logic [OP_W-1:0] OP_DROP_CHUNK = 3'd4;
  localparam logic [OP_W-1:0] OP_TICK       = 3'd5;
  localparam logic [OP_W-1:0] OP_QUERY      = 3'd6;

  localparam logic [KIND_W-1:0] KIND_STATUS = 2'd0;
  localparam logic [KIND_W-1:0] KIND_SENT   = 2'd1;
  localparam logic [KIND_W-1:0] KIND_QUERY  = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_MAX_BLOCK = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT   = 1'd1;

  localparam logic [WORD_W-1:0] MAX_BLOCK_RESET = 32'd32768;
  localparam logic [TOUT_W-1:0] TIMEOUT_RESET   = 16'd10;

  typedef struct packed {
    logic [KEY_W-1:0]  chunk;
    logic [WORD_W-1:0] offset;
    logic [WORD_W-1:0] size;
    logic [PEER_W-1:0] peer;
    logic [WORD_W-1:0] started;
    logic [WORD_W-1:0] expires;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic              removed;
    logic              full;
    entry_t            ent;
    logic              last;
  } result_t;

endpackage

// ===== rtl/ort_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module ort_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== rtl/ort_match.sv =====
// Decides whether one table entry matches the request under the current operation.
module ort_match
  import ort_pkg::*;
(
  input  entry_t            ent,
  input  logic [OP_W-1:0]   op,
  input  logic [KEY_W-1:0]  key,
  input  logic [WORD_W-1:0] offset,
  input  logic [WORD_W-1:0] size,
  input  logic [PEER_W-1:0] peer,
  input  logic [WORD_W-1:0] time_now,
  output logic              hit
);

  logic [WORD_W-1:0] age;
  logic              key_eq;

  // An entry has expired once the wrapped distance past its expiry is non-negative.
  assign age    = time_now - ent.expires;
  assign key_eq = (ent.chunk == key);

  always_comb begin
    case (op)
      OP_COMPLETE:   hit = key_eq && (ent.offset == offset) && (ent.size == size) &&
                           (ent.peer == peer);
      OP_EXPIRE:     hit = !age[WORD_W-1];
      OP_DROP_PEER:  hit = (ent.peer == peer);
      OP_DROP_CHUNK: hit = key_eq;
      OP_QUERY:      hit = key_eq;
      default:       hit = 1'b0;
    endcase
  end

endmodule

// ===== rtl/outstanding_request_tracker_top.sv =====
// Outstanding request tracker: table of pending block requests with timeout.
//
// Requests enter on the in_valid/in_ready channel; results leave on the
// out_valid/out_ready channel, one output register between the two sides.
// The configuration port (cfg_write, cfg_index, cfg_data) sets the block size
// limit and the timeout; write it only while no request is in flight.
// Entry payloads live in one RAM with registered read data; valid bits are
// flip-flops. Every table operation walks the RAM one entry per cycle, except
// while a query waits for the output register; create ends early at the first
// free slot, while tick, the unused opcode and a create for an out-of-range
// peer skip the walk. A new request is taken once the previous one has placed
// its final result in the output register, even while that result still waits.
// A query emits one result per matching entry, up to MAX_RESULTS; if the
// receiver stalls, the scan holds on the next match until the output register
// frees up. Reset clears all valid bits, the time counter and the output valid
// flag, and restores the configuration defaults; the RAM needs no clearing.
module outstanding_request_tracker_top
  import ort_pkg::*;
#(
  parameter int TABLE_DEPTH = 16,
  parameter int PEER_COUNT  = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_write,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [WORD_W-1:0]    cfg_data,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [OP_W-1:0]      op,
  input  logic [KEY_W-1:0]     chunk_key,
  input  logic [WORD_W-1:0]    block_offset,
  input  logic [WORD_W-1:0]    block_size,
  input  logic [PEER_W-1:0]    peer_index,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [KIND_W-1:0]    kind,
  output logic                 removed_any,
  output logic                 table_full,
  output logic [KEY_W-1:0]     out_chunk_key,
  output logic [WORD_W-1:0]    out_offset,
  output logic [WORD_W-1:0]    out_size,
  output logic [PEER_W-1:0]    out_peer,
  output logic [WORD_W-1:0]    out_started,
  output logic [WORD_W-1:0]    out_expires,
  output logic                 last
);

  localparam int IDX_W = $clog2(TABLE_DEPTH);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_DEPTH - 1);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_PRIME = 2'd1;
  localparam logic [1:0] S_SCAN  = 2'd2;
  localparam logic [1:0] S_DONE  = 2'd3;

  logic [1:0]             state, state_next;
  logic [TABLE_DEPTH-1:0] entry_valid, entry_valid_next;
  logic [WORD_W-1:0]      time_now, time_now_next;
  logic [WORD_W-1:0]      max_block_size;
  logic [TOUT_W-1:0]      timeout_ticks;

  logic [OP_W-1:0]        req_op;
  logic [KEY_W-1:0]       req_key;
  logic [WORD_W-1:0]      req_offset;
  logic [WORD_W-1:0]      req_size;
  logic [WORD_W-1:0]      req_csize;
  logic [WORD_W-1:0]      req_expires;
  logic [PEER_W-1:0]      req_peer;
  logic [KIND_W-1:0]      fin_kind, fin_kind_next;

  logic [IDX_W-1:0]       cmp_idx, cmp_idx_next;
  logic [CNT_W-1:0]       found_cnt, found_cnt_next;
  logic                   removed, removed_next;
  logic                   full, full_next;
  logic                   pend_valid, pend_valid_next;
  entry_t                 pend, pend_next;

  result_t                out_q, out_next;
  logic                   out_load;
  logic                   out_free;

  logic                   in_accept;
  logic                   rd_en;
  logic [IDX_W-1:0]       rd_addr;
  logic [ENTRY_W-1:0]     rd_data;
  logic                   wr_en;
  entry_t                 new_ent;
  entry_t                 ent;
  logic                   hit;
  logic                   cur_valid;

  assign in_ready  = (state == S_IDLE);
  assign in_accept = in_valid && in_ready;
  assign out_free  = !out_valid || out_ready;
  assign ent       = entry_t'(rd_data);
  assign cur_valid = entry_valid[cmp_idx];

  assign new_ent = '{chunk: req_key, offset: req_offset, size: req_csize,
                     peer: req_peer, started: time_now, expires: req_expires};

  ort_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (cmp_idx),
    .wr_data (new_ent),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  ort_match u_match (
    .ent      (ent),
    .op       (req_op),
    .key      (req_key),
    .offset   (req_offset),
    .size     (req_size),
    .peer     (req_peer),
    .time_now (time_now),
    .hit      (hit)
  );

  always_comb begin
    state_next       = state;
    entry_valid_next = entry_valid;
    time_now_next    = time_now;
    fin_kind_next    = fin_kind;
    cmp_idx_next     = cmp_idx;
    found_cnt_next   = found_cnt;
    removed_next     = removed;
    full_next        = full;
    pend_valid_next  = pend_valid;
    pend_next        = pend;
    out_load         = 1'b0;
    out_next         = out_q;
    rd_en            = 1'b0;
    rd_addr          = cmp_idx + 1'b1;
    wr_en            = 1'b0;

    unique case (state)
      S_IDLE: begin
        if (in_accept) begin
          removed_next    = 1'b0;
          full_next       = 1'b0;
          pend_valid_next = 1'b0;
          found_cnt_next  = '0;
          fin_kind_next   = (op == OP_QUERY) ? KIND_QUERY : KIND_SENT;
          unique case (op) inside
            OP_CREATE: begin
              if (32'(peer_index) >= 32'(PEER_COUNT)) begin
                state_next = S_DONE;
              end else begin
                state_next = S_PRIME;
              end
            end
            OP_COMPLETE, OP_EXPIRE, OP_DROP_PEER, OP_DROP_CHUNK, OP_QUERY: begin
              state_next = S_PRIME;
            end
            OP_TICK: begin
              time_now_next = time_now + 1'b1;
              state_next    = S_DONE;
            end
            default: begin
              state_next = S_DONE;
            end
          endcase
        end
      end

      S_PRIME: begin
        rd_en        = 1'b1;
        rd_addr      = '0;
        cmp_idx_next = '0;
        state_next   = S_SCAN;
      end

      S_SCAN: begin
        case (req_op)
          OP_CREATE: begin
            if (!cur_valid) begin
              wr_en                     = 1'b1;
              entry_valid_next[cmp_idx] = 1'b1;
              pend_next                 = new_ent;
              pend_valid_next           = 1'b1;
              state_next                = S_DONE;
            end else if (cmp_idx == LAST_IDX) begin
              full_next  = 1'b1;
              state_next = S_DONE;
            end else begin
              rd_en        = 1'b1;
              cmp_idx_next = cmp_idx + 1'b1;
            end
          end

          OP_QUERY: begin
            // A match is held back until the next one is found so the final one can carry last.
            if (cur_valid && hit) begin
              if (!pend_valid || out_free) begin
                if (pend_valid) begin
                  out_load = 1'b1;
                  out_next = '{kind: KIND_QUERY, removed: 1'b0, full: 1'b0,
                               ent: pend, last: 1'b0};
                end
                pend_next       = ent;
                pend_valid_next = 1'b1;
                found_cnt_next  = found_cnt + 1'b1;
                if (found_cnt == CNT_W'(MAX_RESULTS - 1) || cmp_idx == LAST_IDX) begin
                  state_next = S_DONE;
                end else begin
                  rd_en        = 1'b1;
                  cmp_idx_next = cmp_idx + 1'b1;
                end
              end
            end else if (cmp_idx == LAST_IDX) begin
              state_next = S_DONE;
            end else begin
              rd_en        = 1'b1;
              cmp_idx_next = cmp_idx + 1'b1;
            end
          end

          default: begin
            if (cur_valid && hit) begin
              entry_valid_next[cmp_idx] = 1'b0;
              removed_next              = 1'b1;
            end
            if (cmp_idx == LAST_IDX) begin
              state_next = S_DONE;
            end else begin
              rd_en        = 1'b1;
              cmp_idx_next = cmp_idx + 1'b1;
            end
          end
        endcase
      end

      S_DONE: begin
        if (out_free) begin
          out_load   = 1'b1;
          state_next = S_IDLE;
          if (pend_valid) begin
            out_next = '{kind: fin_kind, removed: 1'b0, full: 1'b0, ent: pend, last: 1'b1};
          end else begin
            out_next = '{kind: KIND_STATUS, removed: removed, full: full, ent: '0,
                         last: 1'b1};
          end
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      entry_valid    <= '0;
      time_now       <= '0;
      max_block_size <= MAX_BLOCK_RESET;
      timeout_ticks  <= TIMEOUT_RESET;
      out_valid      <= 1'b0;
      pend_valid     <= 1'b0;
      removed        <= 1'b0;
      full           <= 1'b0;
      found_cnt      <= '0;
      cmp_idx        <= '0;
    end else begin
      state       <= state_next;
      entry_valid <= entry_valid_next;
      time_now    <= time_now_next;
      pend_valid  <= pend_valid_next;
      removed     <= removed_next;
      full        <= full_next;
      found_cnt   <= found_cnt_next;
      cmp_idx     <= cmp_idx_next;
      if (cfg_write && cfg_index == CFG_MAX_BLOCK) begin
        max_block_size <= cfg_data;
      end
      if (cfg_write && cfg_index == CFG_TIMEOUT) begin
        timeout_ticks <= cfg_data[TOUT_W-1:0];
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    pend     <= pend_next;
    fin_kind <= fin_kind_next;
    if (out_load) begin
      out_q <= out_next;
    end
    if (in_accept) begin
      req_op      <= op;
      req_key     <= chunk_key;
      req_offset  <= block_offset;
      req_size    <= block_size;
      req_peer    <= peer_index;
      req_csize   <= (block_size < max_block_size) ? block_size : max_block_size;
      req_expires <= time_now + WORD_W'(timeout_ticks);
    end
  end

  assign kind          = out_q.kind;
  assign removed_any   = out_q.removed;
  assign table_full    = out_q.full;
  assign out_chunk_key = out_q.ent.chunk;
  assign out_offset    = out_q.ent.offset;
  assign out_size      = out_q.ent.size;
  assign out_peer      = out_q.ent.peer;
  assign out_started   = out_q.ent.started;
  assign out_expires   = out_q.ent.expires;
  assign last          = out_q.last;

  // A result must never overwrite one the receiver has not yet taken.
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    out_load |-> (!out_valid || out_ready))
    else $error("output register overwritten while stalled");

  // A table write only happens for a create, and that slot is valid afterwards.
  a_write_sets_valid: assert property (@(posedge clk) disable iff (rst)
    wr_en |=> (entry_valid[$past(cmp_idx)] && $past(req_op) == OP_CREATE))
    else $error("table write without matching valid bit");

  // The time counter only moves when a tick request is accepted.
  a_time_on_tick: assert property (@(posedge clk) disable iff (rst)
    !(in_accept && op == OP_TICK) |=> $stable(time_now))
    else $error("time counter moved without a tick");

endmodule
